[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the command collector checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check on the usual clock and reset names of the checker.
`define ASSERT_STD(label, prop, msg) \
   `ASSERT_CLK(label, clock, reset, prop, msg)

`endif

[sv/sccc_pkg.sv]
// ----------------------------------------------------------------------------
// Command collector package
// Payload structs, operation, kind and status codes, and controller types.
// ----------------------------------------------------------------------------
package sccc_pkg;

   localparam logic [1:0] OP_RESERVE = 2'd0;
   localparam logic [1:0] OP_FILL    = 2'd1;
   localparam logic [1:0] OP_SQUASH  = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   localparam logic [2:0] KIND_CONFIG    = 3'd0;
   localparam logic [2:0] KIND_APPEND    = 3'd1;
   localparam logic [2:0] KIND_START     = 3'd2;
   localparam logic [2:0] KIND_END       = 3'd3;
   localparam logic [2:0] KIND_START_END = 3'd4;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [2:0] STAT_INVALID   = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_BUSY      = 3'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic [4:0]  stream_id;
      logic [31:0] seq_num;
      logic [2:0]  cmd_kind;
      logic [63:0] cmd_word;
      logic        engine_free;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        launch;
      logic [4:0]  out_stream;
      logic [31:0] out_seq;
      logic [2:0]  out_kind;
      logic [63:0] out_word;
      logic        last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISP,
      ST_SQ_RD,
      ST_SQ_EV,
      ST_SQ_END,
      ST_FL_RD,
      ST_FL_EV,
      ST_FL_CHK,
      ST_VA_RD,
      ST_VA_EV,
      ST_VA_DEC,
      ST_LN_RD,
      ST_LN_EV,
      ST_LN_CRD,
      ST_LN_EMIT,
      ST_WAIT,
      ST_WAIT_LN
   } state_type;

   typedef struct packed {
      logic       load;
      logic       rsv_do;
      logic       idx_clr;
      logic       idx_inc;
      logic       sq_ev;
      logic       fl_wr;
      logic       va_ev;
      logic       ln_clr;
      logic       ln_ev;
      logic       sel_best;
      logic       ln_emit;
      logic       rsp_set;
      logic [2:0] rsp_code;
   } dp_cmd_type;

   typedef struct packed {
      logic       in_range;
      logic [1:0] op;
      logic       free_any;
      logic       hit;
      logic       idx_last;
      logic       any;
      logic       pending_any;
      logic       set_ok;
      logic       efree;
      logic       rsp_valid;
      logic       rsp_last;
   } dp_stat_type;

endpackage

[sv/sccc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sccc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sccc_dp.sv]
// ----------------------------------------------------------------------------
// Command collector datapath
// Slot memories, occupancy bits, scan index, flags and the result register.
// ----------------------------------------------------------------------------
module sccc_dp #(
   parameter int NUM_STREAMS      = 32,
   parameter int SLOTS_PER_STREAM = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  sccc_pkg::req_type   req_data,
   input  logic                rsp_stall,
   input  sccc_pkg::dp_cmd_type cmd,
   output sccc_pkg::dp_stat_type stat,
   output sccc_pkg::rsp_type   rsp_data,
   output logic                rsp_valid
);
   import sccc_pkg::*;

   localparam int S     = SLOTS_PER_STREAM;
   localparam int NSLOT = NUM_STREAMS * SLOTS_PER_STREAM;
   localparam int AW    = $clog2(NSLOT);
   localparam int IW    = $clog2(SLOTS_PER_STREAM);
   localparam int CW    = 67;

   req_type          item_ff;
   logic [IW-1:0]    idx_ff, idx_in;
   logic             any_ff, any_in;
   logic             hs_ff, hs_in, he_ff, he_in, bad_ff, bad_in;
   logic             have_ff, have_in;
   logic [IW-1:0]    best_ff, best_in;
   logic [31:0]      best_seq_ff, best_seq_in;
   logic [NSLOT-1:0] valid_ff, valid_in, complete_ff, complete_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]    base, addr_idx, addr_best, addr_free;
   logic [S-1:0]     vec, cvec, vec_nb;
   logic [IW-1:0]    free_idx;
   logic [31:0]      seq_q;
   logic [CW-1:0]    cmd_q;
   logic [2:0]       kind_q;
   logic             cur_valid, sq_hit, ln_better;

   assign base      = AW'(32'(item_ff.stream_id) * S);
   assign addr_idx  = base + AW'(idx_ff);
   assign addr_best = base + AW'(best_ff);
   assign addr_free = base + AW'(free_idx);
   assign vec       = valid_ff[base +: S];
   assign cvec      = complete_ff[base +: S];
   assign cur_valid = vec[idx_ff];
   assign kind_q    = cmd_q[CW-1 -: 3];

   always_comb begin
      free_idx = '0;
      for (int i = S - 1; i >= 0; i--) begin
         if (!vec[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   sccc_ram #(.WIDTH(32), .DEPTH(NSLOT)) u_seq_ram (
      .clock   (clock),
      .wr_en   (cmd.rsv_do && stat.free_any),
      .wr_addr (addr_free),
      .wr_data (item_ff.seq_num),
      .rd_addr (addr_idx),
      .rd_data (seq_q)
   );

   sccc_ram #(.WIDTH(CW), .DEPTH(NSLOT)) u_cmd_ram (
      .clock   (clock),
      .wr_en   (cmd.fl_wr),
      .wr_addr (addr_idx),
      .wr_data ({item_ff.cmd_kind, item_ff.cmd_word}),
      .rd_addr (cmd.sel_best ? addr_best : addr_idx),
      .rd_data (cmd_q)
   );

   assign sq_hit    = cur_valid && (seq_q >= item_ff.seq_num);
   assign ln_better = cur_valid && (!have_ff || (seq_q < best_seq_ff));
   assign vec_nb    = vec & ~(S'(1) << best_ff);

   always_comb begin
      idx_in       = idx_ff;
      any_in       = any_ff;
      hs_in        = hs_ff;
      he_in        = he_ff;
      bad_in       = bad_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      best_seq_in  = best_seq_ff;
      valid_in     = valid_ff;
      complete_in  = complete_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.load) begin
         any_in = 1'b0;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
         hs_in  = 1'b0;
         he_in  = 1'b0;
         bad_in = 1'b0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IW'(1);
      end
      if (cmd.rsv_do && stat.free_any) begin
         valid_in[addr_free]    = 1'b1;
         complete_in[addr_free] = 1'b0;
      end
      if (cmd.sq_ev && sq_hit) begin
         valid_in[addr_idx]    = 1'b0;
         complete_in[addr_idx] = 1'b0;
         any_in                = 1'b1;
      end
      if (cmd.fl_wr) begin
         complete_in[addr_idx] = 1'b1;
      end
      if (cmd.va_ev && cur_valid) begin
         unique case (kind_q)
            KIND_CONFIG, KIND_APPEND: begin
            end
            KIND_START: begin
               bad_in = bad_ff | hs_ff;
               hs_in  = 1'b1;
            end
            KIND_END: begin
               bad_in = bad_ff | he_ff;
               he_in  = 1'b1;
            end
            KIND_START_END: begin
               bad_in = bad_ff | hs_ff | he_ff;
               hs_in  = 1'b1;
               he_in  = 1'b1;
            end
            default: begin
               bad_in = 1'b1;
            end
         endcase
      end
      if (cmd.ln_clr) begin
         have_in = 1'b0;
      end
      if (cmd.ln_ev && ln_better) begin
         have_in     = 1'b1;
         best_in     = idx_ff;
         best_seq_in = seq_q;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_set) begin
         rsp_in       = '0;
         rsp_in.status     = cmd.rsp_code;
         rsp_in.out_stream = item_ff.stream_id;
         rsp_in.last       = 1'b1;
         rsp_valid_in      = 1'b1;
      end
      if (cmd.ln_emit) begin
         rsp_in.status     = STAT_OK;
         rsp_in.launch     = 1'b1;
         rsp_in.out_stream = item_ff.stream_id;
         rsp_in.out_seq    = best_seq_ff;
         rsp_in.out_kind   = kind_q;
         rsp_in.out_word   = cmd_q[63:0];
         rsp_in.last       = (vec_nb == '0);
         rsp_valid_in      = 1'b1;
         valid_in[addr_best]    = 1'b0;
         complete_in[addr_best] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      idx_ff      <= idx_in;
      any_ff      <= any_in;
      hs_ff       <= hs_in;
      he_ff       <= he_in;
      bad_ff      <= bad_in;
      have_ff     <= have_in;
      best_ff     <= best_in;
      best_seq_ff <= best_seq_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         valid_ff     <= '0;
         complete_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         complete_ff  <= complete_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.in_range    = (32'(item_ff.stream_id) < NUM_STREAMS);
   assign stat.op          = item_ff.op;
   assign stat.free_any    = ~&vec;
   assign stat.hit         = cur_valid && (seq_q == item_ff.seq_num);
   assign stat.idx_last    = (idx_ff == IW'(S - 1));
   assign stat.any         = any_ff;
   assign stat.pending_any = |(vec & ~cvec);
   assign stat.set_ok      = !bad_ff && hs_ff && he_ff;
   assign stat.efree       = item_ff.engine_free;
   assign stat.rsp_valid   = rsp_valid_ff;
   assign stat.rsp_last    = rsp_ff.last;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/sccc_ctrl.sv]
// ----------------------------------------------------------------------------
// Command collector controller
// Sequences reserve, squash, fill, validation and launch over the datapath.
// ----------------------------------------------------------------------------
module sccc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sccc_pkg::dp_stat_type stat,
   output sccc_pkg::dp_cmd_type  cmd
);
   import sccc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            cmd.idx_clr = 1'b1;
            if (!stat.in_range) begin
               cmd.rsp_set  = 1'b1;
               cmd.rsp_code = STAT_NOT_FOUND;
               state_in     = ST_WAIT;
            end else begin
               unique case (stat.op)
                  OP_RESERVE: begin
                     cmd.rsv_do   = 1'b1;
                     cmd.rsp_set  = 1'b1;
                     cmd.rsp_code = stat.free_any ? STAT_OK : STAT_FULL;
                     state_in     = ST_WAIT;
                  end
                  OP_FILL:   state_in = ST_FL_RD;
                  OP_SQUASH: state_in = ST_SQ_RD;
                  OP_NOP: begin
                     cmd.rsp_set  = 1'b1;
                     cmd.rsp_code = STAT_OK;
                     state_in     = ST_WAIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQ_RD: state_in = ST_SQ_EV;
         ST_SQ_EV: begin
            cmd.sq_ev = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_SQ_END;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SQ_RD;
            end
         end
         ST_SQ_END: begin
            cmd.rsp_set  = 1'b1;
            cmd.rsp_code = stat.any ? STAT_OK : STAT_NOT_FOUND;
            state_in     = ST_WAIT;
         end
         ST_FL_RD: state_in = ST_FL_EV;
         ST_FL_EV: begin
            priority if (stat.hit) begin
               cmd.fl_wr = 1'b1;
               state_in  = ST_FL_CHK;
            end else if (stat.idx_last) begin
               cmd.rsp_set  = 1'b1;
               cmd.rsp_code = STAT_NOT_FOUND;
               state_in     = ST_WAIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_FL_RD;
            end
         end
         ST_FL_CHK: begin
            if (stat.pending_any) begin
               cmd.rsp_set  = 1'b1;
               cmd.rsp_code = STAT_OK;
               state_in     = ST_WAIT;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_VA_RD;
            end
         end
         ST_VA_RD: state_in = ST_VA_EV;
         ST_VA_EV: begin
            cmd.va_ev = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_VA_DEC;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_VA_RD;
            end
         end
         ST_VA_DEC: begin
            priority if (!stat.set_ok) begin
               cmd.rsp_set  = 1'b1;
               cmd.rsp_code = STAT_INVALID;
               state_in     = ST_WAIT;
            end else if (!stat.efree) begin
               cmd.rsp_set  = 1'b1;
               cmd.rsp_code = STAT_BUSY;
               state_in     = ST_WAIT;
            end else begin
               cmd.idx_clr = 1'b1;
               cmd.ln_clr  = 1'b1;
               state_in    = ST_LN_RD;
            end
         end
         ST_LN_RD: state_in = ST_LN_EV;
         ST_LN_EV: begin
            cmd.ln_ev = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_LN_CRD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_LN_RD;
            end
         end
         ST_LN_CRD: begin
            cmd.sel_best = 1'b1;
            state_in     = ST_LN_EMIT;
         end
         ST_LN_EMIT: begin
            cmd.ln_emit = 1'b1;
            state_in    = ST_WAIT_LN;
         end
         ST_WAIT: begin
            if (!stat.rsp_valid) begin
               state_in = ST_IDLE;
            end
         end
         ST_WAIT_LN: begin
            if (!stat.rsp_valid) begin
               if (stat.rsp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx_clr = 1'b1;
                  cmd.ln_clr  = 1'b1;
                  state_in    = ST_LN_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[sv/stream_config_command_collector_top.sv]
// A reserve, a nop or an out-of-range stream is answered straight from dispatch; a fill or a squash
// first scans the stream's slots one at a time, each slot read from the registered slot memories
// before it is evaluated. A fill that completes a set then scans again to validate it, and a valid
// set is launched in sequence order, one scan per launched command, each issued only after the
// previous result is taken.
// One request at a time, taken after its last result is taken; synchronous reset empties all slots.
// ----------------------------------------------------------------------------
// Stream command collector top level
// Collects per-stream command slots, validates complete sets and launches
// them in sequence order.
// ----------------------------------------------------------------------------
module stream_config_command_collector_top #(
   parameter int NUM_STREAMS      = 32,
   parameter int SLOTS_PER_STREAM = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sccc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sccc_pkg::rsp_type rsp_data
);
   import sccc_pkg::*;

   // The controller issues one command word per cycle and reads back the
   // datapath status; the two are joined by nothing else.
   dp_cmd_type  cmd;
   dp_stat_type stat;

   sccc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the slot memories, the occupancy and completion
   // bits, the scan state and the result register that faces the consumer.
   sccc_dp #(
      .NUM_STREAMS      (NUM_STREAMS),
      .SLOTS_PER_STREAM (SLOTS_PER_STREAM)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule

[sv/sccc_chk.sv]
// ----------------------------------------------------------------------------
// Command collector checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sccc_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input sccc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sccc_pkg::rsp_type rsp_data
);
   import sccc_pkg::*;

   logic req_wait, rsp_wait, plain_rsp, plain_clear, launch_rsp;

   assign req_wait    = req_valid && req_stall;
   assign rsp_wait    = rsp_valid && rsp_stall;
   assign plain_rsp   = rsp_valid && !rsp_data.launch;
   assign launch_rsp  = rsp_valid && rsp_data.launch;
   assign plain_clear = (rsp_data.out_seq == 32'd0) && (rsp_data.out_kind == 3'd0) &&
                        (rsp_data.out_word == 64'd0) && rsp_data.last;

   `ASSERT_STD(a_rsp_hold, rsp_wait |=> rsp_valid && $stable(rsp_data), "held result changed")
   `ASSERT_STD(a_req_hold, req_wait |=> req_valid && $stable(req_data), "held request changed")
   `ASSERT_STD(a_plain_zero, plain_rsp |-> plain_clear, "plain result payload not cleared")
   `ASSERT_STD(a_launch_ok, launch_rsp |-> rsp_data.status == STAT_OK, "launch with error status")
   `ASSERT_STD(a_one_req, rsp_valid |-> req_stall, "request taken while a result is pending")

endmodule

bind stream_config_command_collector_top sccc_chk u_chk (.*);

[test/tb_stream_config_command_collector_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command collector testbench
// Drives reserve, fill, squash and unused-op requests into the collector and
// checks every result against a behavioral predictor of the slot tables.
// ----------------------------------------------------------------------------
module tb_stream_config_command_collector_top;
   import sccc_pkg::*;

   localparam int NSTREAM = 32;
   localparam int NSLOTS  = 8;
   localparam int NTOTAL  = NSTREAM * NSLOTS;
   localparam longint CYCLE_LIMIT = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   stream_config_command_collector_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Predictor copy of the slot tables.
   bit          tbl_used [NTOTAL];
   bit          tbl_done [NTOTAL];
   logic [31:0] tbl_seq  [NTOTAL];
   logic [2:0]  tbl_kind [NTOTAL];
   logic [63:0] tbl_word [NTOTAL];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      error_count = 0;
   longint  cycle_count = 0;
   bit      stimulus_done = 1'b0;
   bit      long_hold = 1'b0;
   bit      sender_pause = 1'b0;

   function automatic rsp_type status_rsp(logic [2:0] code, logic [4:0] sid);
      rsp_type r;
      r = '0;
      r.status = code;
      r.out_stream = sid;
      r.last = 1'b1;
      return r;
   endfunction

   // Start/end rules of one stream's set of occupied slots.
   function automatic bit set_ok(int base);
      bit st, en;
      st = 0;
      en = 0;
      for (int i = 0; i < NSLOTS; i++) begin
         if (!tbl_used[base+i]) continue;
         case (tbl_kind[base+i])
            KIND_CONFIG, KIND_APPEND: ;
            KIND_START: begin
               if (st) return 0;
               st = 1;
            end
            KIND_END: begin
               if (en) return 0;
               en = 1;
            end
            KIND_START_END: begin
               if (st || en) return 0;
               st = 1;
               en = 1;
            end
            default: return 0;
         endcase
      end
      return st && en;
   endfunction

   // Updates the tables for one accepted request and queues its results.
   task automatic predict_collector(req_type q);
      int base, hit, cnt, best;
      bit any;
      rsp_type r;
      base = q.stream_id * NSLOTS;
      case (q.op)
         OP_RESERVE: begin
            hit = -1;
            for (int i = 0; i < NSLOTS; i++)
               if (hit < 0 && !tbl_used[base+i]) hit = i;
            if (hit < 0) begin
               expected_rsps.push_back(status_rsp(STAT_FULL, q.stream_id));
            end else begin
               tbl_used[base+hit] = 1;
               tbl_done[base+hit] = 0;
               tbl_seq[base+hit] = q.seq_num;
               expected_rsps.push_back(status_rsp(STAT_OK, q.stream_id));
            end
         end
         OP_SQUASH: begin
            any = 0;
            for (int i = 0; i < NSLOTS; i++)
               if (tbl_used[base+i] && tbl_seq[base+i] >= q.seq_num) begin
                  tbl_used[base+i] = 0;
                  tbl_done[base+i] = 0;
                  any = 1;
               end
            expected_rsps.push_back(status_rsp(any ? STAT_OK : STAT_NOT_FOUND,
                                               q.stream_id));
         end
         OP_FILL: begin
            hit = -1;
            for (int i = 0; i < NSLOTS; i++)
               if (hit < 0 && tbl_used[base+i] && tbl_seq[base+i] == q.seq_num)
                  hit = i;
            if (hit < 0) begin
               expected_rsps.push_back(status_rsp(STAT_NOT_FOUND, q.stream_id));
               return;
            end
            tbl_kind[base+hit] = q.cmd_kind;
            tbl_word[base+hit] = q.cmd_word;
            tbl_done[base+hit] = 1;
            for (int i = 0; i < NSLOTS; i++)
               if (tbl_used[base+i] && !tbl_done[base+i]) begin
                  expected_rsps.push_back(status_rsp(STAT_OK, q.stream_id));
                  return;
               end
            if (!set_ok(base)) begin
               expected_rsps.push_back(status_rsp(STAT_INVALID, q.stream_id));
               return;
            end
            if (!q.engine_free) begin
               expected_rsps.push_back(status_rsp(STAT_BUSY, q.stream_id));
               return;
            end
            cnt = 0;
            for (int i = 0; i < NSLOTS; i++) if (tbl_used[base+i]) cnt++;
            for (int k = 0; k < cnt; k++) begin
               best = -1;
               for (int i = 0; i < NSLOTS; i++)
                  if (tbl_used[base+i] &&
                      (best < 0 || tbl_seq[base+i] < tbl_seq[base+best]))
                     best = i;
               r = '0;
               r.status = STAT_OK;
               r.launch = 1'b1;
               r.out_stream = q.stream_id;
               r.out_seq = tbl_seq[base+best];
               r.out_kind = tbl_kind[base+best];
               r.out_word = tbl_word[base+best];
               r.last = (k == cnt - 1);
               expected_rsps.push_back(r);
               tbl_used[base+best] = 0;
               tbl_done[base+best] = 0;
            end
         end
         default: expected_rsps.push_back(status_rsp(STAT_OK, q.stream_id));
      endcase
   endtask

   function automatic req_type make_req(logic [1:0] op, int sid, logic [31:0] seq,
                                        logic [2:0] kind, bit efree);
      req_type q;
      q.op = op;
      q.stream_id = 5'(sid);
      q.seq_num = seq;
      q.cmd_kind = kind;
      q.cmd_word = {$urandom, $urandom};
      q.engine_free = efree;
      return q;
   endfunction

   // Queues a command set, well-formed unless corrupted: reserves, then fills in random order.
   task automatic add_command_set(int sid, int n, bit efree);
      logic [31:0] seqs[$];
      logic [2:0]  kinds[$];
      int j;
      logic [31:0] t;
      logic [31:0] base_seq;
      base_seq = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 : $urandom_range(0, 1000);
      for (int i = 0; i < n; i++) begin
         seqs.push_back(($urandom_range(0, 7) == 0 && i > 0) ? seqs[i-1]
                        : base_seq + $urandom_range(0, 12));
         kinds.push_back($urandom_range(0, 1) ? KIND_APPEND : KIND_CONFIG);
      end
      if (n == 1 || $urandom_range(0, 2) == 0) begin
         kinds[0] = KIND_START_END;
      end else begin
         kinds[0] = KIND_START;
         kinds[1] = KIND_END;
      end
      // Occasionally corrupt the set so that validation rejects it.
      if ($urandom_range(0, 7) == 0) kinds[$urandom_range(0, n-1)] = 3'($urandom_range(0, 7));
      for (int i = 0; i < n; i++)
         pending_reqs.push_back(make_req(OP_RESERVE, sid, seqs[i], 0, 1));
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = seqs[i]; seqs[i] = seqs[j]; seqs[j] = t;
      end
      for (int i = 0; i < n; i++)
         pending_reqs.push_back(make_req(OP_FILL, sid, seqs[i], kinds[i], efree));
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   // Stimulus: directed cases, then random sets mixed with noise.
   initial begin
      req_type q;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // Directed: fill with no match, squash of nothing, unused op, a full table.
      pending_reqs.push_back(make_req(OP_FILL, 0, 32'd5, KIND_START, 1));
      pending_reqs.push_back(make_req(OP_SQUASH, 31, 32'hFFFF_FFFF, 0, 1));
      pending_reqs.push_back(make_req(OP_NOP, 3, 32'h1234, 3'd7, 1));
      for (int i = 0; i < NSLOTS + 1; i++)
         pending_reqs.push_back(make_req(OP_RESERVE, 31, 32'hFFFF_FFFF - i, 0, 1));
      pending_reqs.push_back(make_req(OP_SQUASH, 31, 32'd0, 0, 1));
      // Directed: valid set busy, refilled when free, and an invalid set.
      pending_reqs.push_back(make_req(OP_RESERVE, 1, 32'd0, 0, 1));
      pending_reqs.push_back(make_req(OP_FILL, 1, 32'd0, KIND_START_END, 0));
      pending_reqs.push_back(make_req(OP_FILL, 1, 32'd0, KIND_START_END, 1));
      pending_reqs.push_back(make_req(OP_RESERVE, 2, 32'd9, 0, 1));
      pending_reqs.push_back(make_req(OP_FILL, 2, 32'd9, 3'd5, 1));
      pending_reqs.push_back(make_req(OP_SQUASH, 2, 32'd9, 0, 1));
      add_command_set(4, NSLOTS, 1);
      wait_drained();

      // The sender pauses here until every result is back.
      sender_pause = 1'b1;
      wait_drained();
      sender_pause = 1'b0;

      while (pending_reqs.size() < 500 || pending_reqs.size() < 10) begin
         if (pending_reqs.size() > 150 && !long_hold) long_hold = 1'b1;
         if ($urandom_range(0, 3) != 0) begin
            add_command_set($urandom_range(0, 7),
                            ($urandom_range(0, 5) == 0) ? NSLOTS : $urandom_range(1, 4),
                            $urandom_range(0, 5) != 0);
         end else begin
            q = make_req(2'($urandom_range(0, 3)), $urandom_range(0, 31),
                         $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1020),
                         3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            q.cmd_word = {$urandom, $urandom};
            pending_reqs.push_back(q);
         end
      end
      wait_drained();
      repeat (200) @(posedge clock);
      stimulus_done = 1'b1;
   end

   // Driver: bursts of requests separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) predict_collector(req_data);
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0 && !sender_pause) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 30);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern, with one long hold-off once the queue is deep.
   int hold_cycles = 0;
   bit hold_used = 1'b0;
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 97;
      if (long_hold && !hold_used) begin
         hold_used <= 1'b1;
         hold_cycles <= 3000;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (stall_phase < 40) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   // Monitor: compares each accepted result with the oldest expectation.
   rsp_type want;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: mismatch expected none actual %h", $realtime, rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: mismatch expected %h actual %h", $realtime, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   // End of run and the overall time limit.
   always @(posedge clock) begin
      if (stimulus_done) begin
         if (error_count == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
         else
            $display("Some tests failed");
         $finish;
      end else if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
